// File: src/stp_pkg.sv
// Shared types, constants and the character decoder of the string-to-integer parser.
// Used by stp_step, string_to_integer_parser and stp_checker; depends on nothing.

package stp_pkg;

   // Field widths
   localparam int NUMBER_W   = 64;
   localparam int STATUS_W   = 2;
   localparam int OFFSET_W   = 16;
   localparam int CHAR_W     = 8;
   localparam int RADIX_W    = 5;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 5;
   localparam int PROD_W     = NUMBER_W + RADIX_W;
   localparam int RSP_PAD_W  = 6;
   localparam int RSP_DATA_W = NUMBER_W + STATUS_W + OFFSET_W + RSP_PAD_W;

   // Saturation point of the consumed-character count
   localparam logic [OFFSET_W-1:0] POSITION_LIMIT = 16'hFFFF;

   // Register reset values
   localparam logic               RESET_ALLOW_SIGN  = 1'b1;
   localparam logic               RESET_SIGNED_MODE = 1'b0;
   localparam logic [RADIX_W-1:0] RESET_BASE        = 5'd10;

   // Characters of interest
   localparam logic [CHAR_W-1:0] CH_NUL   = 8'h00;
   localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2B;
   localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
   localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
   localparam logic [CHAR_W-1:0] CH_NINE  = 8'h39;
   localparam logic [CHAR_W-1:0] CH_UA    = 8'h41;
   localparam logic [CHAR_W-1:0] CH_UF    = 8'h46;
   localparam logic [CHAR_W-1:0] CH_LA    = 8'h61;
   localparam logic [CHAR_W-1:0] CH_LF    = 8'h66;
   localparam logic [CHAR_W-1:0] CH_LB    = 8'h62;
   localparam logic [CHAR_W-1:0] CH_LO    = 8'h6F;
   localparam logic [CHAR_W-1:0] CH_LX    = 8'h78;

   // Radices selected by a prefix
   localparam logic [RADIX_W-1:0] RADIX_HEX = 5'd16;
   localparam logic [RADIX_W-1:0] RADIX_OCT = 5'd8;
   localparam logic [RADIX_W-1:0] RADIX_BIN = 5'd2;

   // Magnitude limits
   localparam logic [NUMBER_W-1:0] LIMIT_UNSIGNED = 64'hFFFF_FFFF_FFFF_FFFF;
   localparam logic [NUMBER_W-1:0] LIMIT_POS      = 64'h7FFF_FFFF_FFFF_FFFF;
   localparam logic [NUMBER_W-1:0] LIMIT_NEG      = 64'h8000_0000_0000_0000;

   typedef enum logic [2:0] {
      PH_START,
      PH_ZERO,
      PH_FIRST,
      PH_DIGITS,
      PH_DONE
   } phase_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK,
      ST_NODIGITS,
      ST_BADDIGIT,
      ST_OVERFLOW
   } status_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_ALLOW_SIGN,
      REG_SIGNED_MODE,
      REG_DEFAULT_BASE
   } csr_index_type;

   typedef struct packed {
      logic               allow_sign;
      logic               signed_mode;
      logic [RADIX_W-1:0] default_base;
   } cfg_type;

   typedef struct packed {
      phase_type           phase;
      logic [RADIX_W-1:0]  radix;
      logic                negative;
      logic [NUMBER_W-1:0] accum;
      logic [OFFSET_W-1:0] position;
      status_type          fstat;
   } parse_state_type;

   typedef struct packed {
      logic [NUMBER_W-1:0] magnitude;
      logic                negative;
      status_type          status;
      logic [OFFSET_W-1:0] offset;
   } result_type;

   typedef struct packed {
      logic       valid;
      logic [3:0] value;
   } digit_type;

   // Map 0-9, A-F, a-f to their digit value
   function automatic digit_type digit_decode(input logic [CHAR_W-1:0] c);
      digit_type d;
      d.valid = 1'b0;
      d.value = 4'd0;
      if (c >= CH_ZERO && c <= CH_NINE) begin
         d.valid = 1'b1;
         d.value = 4'(c - CH_ZERO);
      end else if (c >= CH_UA && c <= CH_UF) begin
         d.valid = 1'b1;
         d.value = 4'(c - CH_UA + 8'd10);
      end else if (c >= CH_LA && c <= CH_LF) begin
         d.valid = 1'b1;
         d.value = 4'(c - CH_LA + 8'd10);
      end
      return d;
   endfunction

endpackage

// File: src/stp_step.sv
// Per-character update of the parser: sign, prefix, digit accumulate, end of string.
// Depends on stp_pkg for the state, result and configuration types.

module stp_step import stp_pkg::*; (
   input  parse_state_type    cur,
   input  cfg_type            cfg,
   input  logic               has_char,
   input  logic [CHAR_W-1:0]  char_code,
   input  logic               last,
   output parse_state_type    nxt,
   output result_type         result
);

   logic [RADIX_W-1:0]  radix_use;
   digit_type           dig;
   logic [PROD_W-1:0]   prod;
   logic [NUMBER_W-1:0] limit;
   logic                first;
   logic                dig_ok;
   logic                overflow;

   // Outcome of one digit character
   phase_type           td_phase;
   status_type          td_stat;
   logic [NUMBER_W-1:0] td_acc;
   logic                td_inc;

   parse_state_type     upd;
   logic [1:0]          inc;
   logic [OFFSET_W:0]   pos_sum;
   status_type          fin_stat;

   // Digit value, radix check and exact overflow check (acc * radix + d > limit)
   always_comb begin
      radix_use = (cur.phase == PH_START) ? cfg.default_base : cur.radix;
      first     = (cur.phase == PH_START) || (cur.phase == PH_FIRST);
      dig       = digit_decode(char_code);
      dig_ok    = dig.valid && (RADIX_W'(dig.value) < radix_use) && (radix_use != '0);
      prod      = PROD_W'(dig.value);
      for (int i = 0; i < RADIX_W; i++) begin
         if (radix_use[i]) begin
            prod = prod + (PROD_W'(cur.accum) << i);
         end
      end
      if (cfg.signed_mode) begin
         limit = cur.negative ? LIMIT_NEG : LIMIT_POS;
      end else begin
         limit = LIMIT_UNSIGNED;
      end
      overflow = prod > PROD_W'(limit);
   end

   // Resolve a digit character: stop, overflow or accumulate
   always_comb begin
      td_phase = PH_DONE;
      td_stat  = cur.fstat;
      td_acc   = cur.accum;
      td_inc   = 1'b0;
      priority if (!first && char_code == CH_NUL) begin
         td_stat = ST_OK;
      end else if (!dig_ok) begin
         td_stat = first ? ST_NODIGITS : ST_BADDIGIT;
      end else if (overflow) begin
         td_stat = ST_OVERFLOW;
      end else begin
         td_acc   = prod[NUMBER_W-1:0];
         td_inc   = 1'b1;
         td_phase = PH_DIGITS;
      end
   end

   // Advance the parse by one character
   always_comb begin
      upd = cur;
      inc = 2'd0;
      if (has_char) begin
         unique case (cur.phase)
            PH_START: begin
               upd.radix = cfg.default_base;
               priority if (cfg.allow_sign && (char_code == CH_PLUS ||
                                               char_code == CH_MINUS)) begin
                  upd.negative = (char_code == CH_MINUS);
                  inc          = 2'd1;
                  upd.phase    = PH_FIRST;
               end else if (char_code == CH_ZERO) begin
                  upd.phase = PH_ZERO;
               end else begin
                  upd.phase = td_phase;
                  upd.fstat = td_stat;
                  upd.accum = td_acc;
                  inc       = {1'b0, td_inc};
               end
            end
            PH_ZERO: begin
               priority if (char_code == CH_LX || char_code == CH_LO ||
                            char_code == CH_LB) begin
                  priority if (char_code == CH_LX) begin
                     upd.radix = RADIX_HEX;
                  end else if (char_code == CH_LO) begin
                     upd.radix = RADIX_OCT;
                  end else begin
                     upd.radix = RADIX_BIN;
                  end
                  inc       = 2'd2;
                  upd.phase = PH_FIRST;
               end else if (cur.radix == '0) begin
                  upd.phase = PH_DONE;
                  upd.fstat = ST_NODIGITS;
               end else begin
                  // the leading zero counts, then the character is a later digit
                  upd.phase = td_phase;
                  upd.fstat = td_stat;
                  upd.accum = td_acc;
                  inc       = 2'd1 + {1'b0, td_inc};
               end
            end
            PH_FIRST, PH_DIGITS: begin
               upd.phase = td_phase;
               upd.fstat = td_stat;
               upd.accum = td_acc;
               inc       = {1'b0, td_inc};
            end
            default: begin
               upd = cur;
            end
         endcase
      end

      // A lone leading zero at the end of the string is the digit zero
      if (last && upd.phase == PH_ZERO && upd.radix != '0) begin
         inc = inc + 2'd1;
      end

      // Saturate the consumed-character count
      pos_sum = (OFFSET_W+1)'(cur.position) + (OFFSET_W+1)'(inc);
      if (pos_sum > (OFFSET_W+1)'(POSITION_LIMIT)) begin
         upd.position = POSITION_LIMIT;
      end else begin
         upd.position = pos_sum[OFFSET_W-1:0];
      end
   end

   // Close the string: pick the status and return to start of string
   always_comb begin
      unique case (upd.phase)
         PH_START, PH_FIRST: fin_stat = ST_NODIGITS;
         PH_ZERO:            fin_stat = (upd.radix == '0) ? ST_NODIGITS : ST_OK;
         PH_DIGITS:          fin_stat = ST_OK;
         default:            fin_stat = upd.fstat;
      endcase

      result.status    = fin_stat;
      result.magnitude = (fin_stat == ST_OK) ? upd.accum : '0;
      result.negative  = upd.negative;
      result.offset    = upd.position;

      nxt = upd;
      if (last) begin
         nxt.phase    = PH_START;
         nxt.radix    = cfg.default_base;
         nxt.negative = 1'b0;
         nxt.accum    = '0;
         nxt.position = '0;
         nxt.fstat    = ST_OK;
      end
   end

endmodule

// File: src/string_to_integer_parser.sv
// Top level of the streaming string-to-integer parser: ports, registers, handshakes.
// Depends on stp_pkg and stp_step.

// One character enters per req_ item (req_tdata = char_code, req_tuser = has_char,
// req_tlast ends the string), and the item flagged last yields one rsp_ item holding
// the value, a status (ok, no digits, bad digit, overflow) and the count of characters
// consumed. One item enters per cycle unless a last item meets a stalled result slot,
// and the result is registered. The digit update (a 64-by-5-bit shift-add multiply and
// limit compare) is combinational from the input register to the parse state.
// A leading sign (if allow_sign is set) or a 0x, 0o, 0b prefix is recognized; a NUL
// ends the number and later characters are ignored until the end of the string. The
// user must write registers over csr_ only while no string is in progress; the block
// does not enforce this. The radix is sampled at the first character of each string.

module string_to_integer_parser import stp_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   // input items
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [CHAR_W-1:0]     req_tdata,   // [7:0] char_code
   input  logic                  req_tuser,   // [0] has_char
   input  logic                  req_tlast,   // last
   // result items
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,   // [63:0] number, [65:64] status,
                                              // [81:66] stop_offset, [87:82] zero
   // register writes
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   cfg_type             cfg_ff, cfg_in;
   parse_state_type     state_ff, state_in;
   parse_state_type     step_nxt;
   result_type          step_res;

   logic                in_valid_ff, in_valid_in;
   logic                in_has_ff;
   logic [CHAR_W-1:0]   in_char_ff;
   logic                in_last_ff;

   logic                out_valid_ff, out_valid_in;
   result_type          out_res_ff;

   logic                fire;
   logic [NUMBER_W-1:0] number_out;

   // Register writes are always taken
   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index)
            REG_ALLOW_SIGN:   cfg_in.allow_sign   = csr_wdata[0];
            REG_SIGNED_MODE:  cfg_in.signed_mode  = csr_wdata[0];
            REG_DEFAULT_BASE: cfg_in.default_base = csr_wdata[RADIX_W-1:0];
            default:          cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.allow_sign   <= RESET_ALLOW_SIGN;
         cfg_ff.signed_mode  <= RESET_SIGNED_MODE;
         cfg_ff.default_base <= RESET_BASE;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Process the held item unless it closes a string and the result slot is full and stalled
   assign fire       = in_valid_ff && (!in_last_ff || !out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || fire;

   assign in_valid_in = req_tready ? req_tvalid : in_valid_ff;

   // Input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         in_has_ff  <= req_tuser;
         in_char_ff <= req_tdata;
         in_last_ff <= req_tlast;
      end
   end

   stp_step u_step (
      .cur       (state_ff),
      .cfg       (cfg_ff),
      .has_char  (in_has_ff),
      .char_code (in_char_ff),
      .last      (in_last_ff),
      .nxt       (step_nxt),
      .result    (step_res)
   );

   // Parse state advances on every processed item
   assign state_in = fire ? step_nxt : state_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff.phase    <= PH_START;
         state_ff.radix    <= RESET_BASE;
         state_ff.negative <= 1'b0;
         state_ff.accum    <= '0;
         state_ff.position <= '0;
         state_ff.fstat    <= ST_OK;
      end else begin
         state_ff <= state_in;
      end
   end

   // Result register: load on a processed last item, drop when taken
   always_comb begin
      out_valid_in = out_valid_ff && !rsp_tready;
      if (fire && in_last_ff) begin
         out_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (fire && in_last_ff) begin
         out_res_ff <= step_res;
      end
   end

   // Apply the sign to the held magnitude
   assign number_out = out_res_ff.negative ? (NUMBER_W'(0) - out_res_ff.magnitude)
                                           : out_res_ff.magnitude;

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {RSP_PAD_W'(0), out_res_ff.offset, out_res_ff.status, number_out};

endmodule

// File: src/stp_checker.sv
// Port-level checks of the string-to-integer parser, bound to its top level.
// Depends on stp_pkg for field widths and status codes.

module stp_checker import stp_pkg::*; (
   input logic                  clock,
   input logic                  reset,
   input logic                  rsp_tvalid,
   input logic                  rsp_tready,
   input logic [RSP_DATA_W-1:0] rsp_tdata
);

   logic [NUMBER_W-1:0] number_w;
   logic [STATUS_W-1:0] status_w;
   logic [OFFSET_W-1:0] offset_w;

   assign number_w = rsp_tdata[NUMBER_W-1:0];
   assign status_w = rsp_tdata[NUMBER_W +: STATUS_W];
   assign offset_w = rsp_tdata[NUMBER_W+STATUS_W +: OFFSET_W];

   // A stalled result item holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result item changed while stalled");

   // Reset empties the result slot
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid right after reset");

   // A failed parse reports zero
   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && status_w != ST_OK |-> number_w == '0)
      else $error("nonzero number with failing status");

   // A nonzero value needs at least one consumed character
   a_value_offset: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && status_w == ST_OK && number_w != '0 |-> offset_w != '0)
      else $error("nonzero number with zero stop offset");

endmodule

bind string_to_integer_parser stp_checker u_stp_checker (.*);
